// File: rtl/brba_pkg.sv
// Package: payload types, interface structs and codes for the byte ring buffer.
package brba_pkg;

    localparam int IDX_W   = 6;
    localparam int PADDR_W = 3;

    // Operation codes
    localparam logic [2:0] OP_APPEND    = 3'd0;
    localparam logic [2:0] OP_SET_START = 3'd1;
    localparam logic [2:0] OP_COPY      = 3'd2;
    localparam logic [2:0] OP_FILL      = 3'd3;
    localparam logic [2:0] OP_MEASURE   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ARG  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    // Register index (word address bit)
    localparam logic REG_RING_LENGTH = 1'b0;
    localparam logic [6:0] RING_LENGTH_RESET = 7'd64;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COPY,
        S_FILL
    } t_state;

    typedef struct packed {
        logic [2:0]       operation;
        logic             first_of_message;
        logic [15:0]      message_length;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       read_byte;
        logic             byte_valid;
        logic [IDX_W-1:0] range_length;
        logic [6:0]       stored_count;
        logic [IDX_W-1:0] start_position;
        logic [15:0]      overflow_events;
        logic [31:0]      lost_bytes_total;
        logic             last;
    } t_result;

    // Register write event toward the controller
    typedef struct packed {
        logic       wr;
        logic [6:0] value;
    } t_cfg_wr;

    // Ring store write port
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
    } t_ram_wr;

endpackage

// File: rtl/brba_ram.sv
// Ring byte store: synchronous memory with per-entry valid bits cleared at reset.
module brba_ram #(
    parameter int RING_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  brba_pkg::t_ram_wr               i_wr,
    input  logic [brba_pkg::IDX_W-1:0]      i_raddr,
    output logic [7:0]                      o_rdata
);
    import brba_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic [7:0]            r_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] r_vld;
    logic [7:0]            r_rdata;
    logic                  r_rvld;

    // Data array write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.waddr[AW-1:0]] <= i_wr.wdata;
        end
        r_rdata <= r_mem[i_raddr[AW-1:0]];
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_wr.waddr[AW-1:0]] <= 1'b1;
            end
            r_rvld <= r_vld[i_raddr[AW-1:0]];
        end
    end

    assign o_rdata = r_rvld ? r_rdata : 8'd0;

endmodule

// File: rtl/brba_apb.sv
// Configuration port: APB slave holding the ring_length register.
module brba_apb (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brba_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [6:0]                      o_ring_length,
    output brba_pkg::t_cfg_wr               o_cfg
);
    import brba_pkg::*;

    logic [6:0] r_ring_length;
    logic       wr_ring_length;

    assign pready = 1'b1;
    assign wr_ring_length = psel && penable && pwrite && pready
                            && (paddr[2] == REG_RING_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_length <= RING_LENGTH_RESET;
        end else if (wr_ring_length) begin
            r_ring_length <= pwdata[6:0];
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[2])
            REG_RING_LENGTH: prdata = {25'd0, r_ring_length};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_ring_length = r_ring_length;
    assign o_cfg.wr      = wr_ring_length;
    assign o_cfg.value   = pwdata[6:0];

endmodule

// File: rtl/brba_ctrl.sv
// Controller: admission, position and counter state, range walks over the store.
module brba_ctrl #(
    parameter int RING_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  brba_pkg::t_item                 i_item,
    output logic                            o_busy,
    input  logic [6:0]                      i_ring_length,
    input  brba_pkg::t_cfg_wr               i_cfg,
    output brba_pkg::t_ram_wr               o_ram_wr,
    output logic [brba_pkg::IDX_W-1:0]      o_ram_raddr,
    input  logic [7:0]                      i_ram_rdata,
    output brba_pkg::t_result               o_result,
    output logic                            o_res_valid
);
    import brba_pkg::*;

    localparam logic [6:0] DEPTH = 7'(RING_DEPTH);

    function automatic logic [6:0] clamp_len(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) r = 7'd1;
        else if (v > DEPTH) r = DEPTH;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                  input logic [6:0] len);
        logic [6:0] s;
        s = {1'b0, idx} + 7'd1;
        return (s >= len) ? '0 : s[IDX_W-1:0];
    endfunction

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [6:0]       r_held, n_held;
    logic [15:0]      r_ovf, n_ovf;
    logic [31:0]      r_lost, n_lost;
    logic [15:0]      r_rem, n_rem;
    logic             r_drop, n_drop;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_rl, n_rl;
    logic [7:0]       r_fill, n_fill;
    t_result          r_res, n_res;
    logic             r_res_valid, n_res_valid;

    logic [6:0]       len;
    logic [6:0]       new_len;
    logic [6:0]       free_sp;
    logic [6:0]       pop;
    logic [6:0]       rl7;
    logic [6:0]       si7, ei7, head7;
    logic             accept;
    logic             put;
    logic             range_bad;
    logic [1:0]       res_status;
    logic [7:0]       res_byte;
    logic             res_bv;
    logic [IDX_W-1:0] res_rl;
    logic             res_last;

    assign len     = clamp_len(i_ring_length);
    assign new_len = clamp_len(i_cfg.value);
    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign si7     = {1'b0, i_item.start_index};
    assign ei7     = {1'b0, i_item.end_index};
    assign head7   = {1'b0, r_head};
    assign free_sp = (r_held >= len) ? 7'd0 : len - r_held;
    assign pop     = (si7 >= head7) ? si7 - head7 : si7 + len - head7;
    assign rl7     = (ei7 >= si7) ? ei7 - si7 : ei7 + len - si7;
    assign range_bad = (si7 >= len) || (ei7 >= len);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_ovf       <= '0;
            r_lost      <= '0;
            r_rem       <= '0;
            r_drop      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_held      <= n_held;
            r_ovf       <= n_ovf;
            r_lost      <= n_lost;
            r_rem       <= n_rem;
            r_drop      <= n_drop;
            r_res_valid <= n_res_valid;
        end
    end

    // Walk and result payload registers
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_rl   <= n_rl;
        r_fill <= n_fill;
        r_res  <= n_res;
    end

    // Next state, store access and result
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_held      = r_held;
        n_ovf       = r_ovf;
        n_lost      = r_lost;
        n_rem       = r_rem;
        n_drop      = r_drop;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_rl        = r_rl;
        n_fill      = r_fill;
        n_res       = r_res;
        n_res_valid = 1'b0;
        o_ram_wr    = '0;
        o_ram_raddr = r_idx;
        put         = 1'b0;
        res_status  = ST_OK;
        res_byte    = 8'd0;
        res_bv      = 1'b0;
        res_rl      = '0;
        res_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_valid = 1'b1;
                    case (i_item.operation) inside
                        OP_APPEND: begin
                            if (i_item.first_of_message) begin
                                if (i_item.message_length == 16'd0) begin
                                    n_rem      = '0;
                                    n_drop     = 1'b0;
                                    res_status = ST_BAD_ARG;
                                end else if (i_item.message_length >= {9'd0, free_sp}) begin
                                    // Whole message rejected
                                    n_ovf      = r_ovf + 16'd1;
                                    n_lost     = r_lost + {16'd0, i_item.message_length};
                                    n_rem      = i_item.message_length - 16'd1;
                                    n_drop     = (i_item.message_length != 16'd1);
                                    res_status = ST_OVERFLOW;
                                end else begin
                                    put    = 1'b1;
                                    n_rem  = i_item.message_length - 16'd1;
                                    n_drop = 1'b0;
                                end
                            end else if (r_rem == 16'd0) begin
                                n_drop     = 1'b0;
                                res_status = ST_BAD_ARG;
                            end else begin
                                n_rem = r_rem - 16'd1;
                                if (r_drop) begin
                                    res_status = ST_OVERFLOW;
                                end else if (r_held >= len) begin
                                    // Ring shrank under an admitted message
                                    res_status = ST_OVERFLOW;
                                    n_drop     = 1'b1;
                                end else begin
                                    put = 1'b1;
                                end
                                if (n_rem == 16'd0) n_drop = 1'b0;
                            end
                        end
                        OP_SET_START: begin
                            if (si7 >= len) begin
                                res_status = ST_RANGE;
                            end else if (i_item.start_index != r_head) begin
                                n_head = i_item.start_index;
                                n_held = (pop >= r_held) ? 7'd0 : r_held - pop;
                            end
                        end
                        OP_COPY, OP_FILL, OP_MEASURE: begin
                            if (range_bad) begin
                                res_status = ST_RANGE;
                            end else begin
                                res_rl = rl7[IDX_W-1:0];
                                n_rl   = rl7[IDX_W-1:0];
                                n_cnt  = rl7[IDX_W-1:0];
                                if (rl7 != 7'd0 && i_item.operation == OP_COPY) begin
                                    // First read now, data returns next cycle
                                    o_ram_raddr = i_item.start_index;
                                    n_idx       = next_idx(i_item.start_index, len);
                                    n_state     = S_COPY;
                                    n_res_valid = 1'b0;
                                end else if (rl7 != 7'd0 && i_item.operation == OP_FILL) begin
                                    n_idx       = i_item.start_index;
                                    n_fill      = i_item.data_byte;
                                    n_state     = S_FILL;
                                    n_res_valid = 1'b0;
                                end
                            end
                        end
                        default: begin
                            res_status = ST_BAD_ARG;
                        end
                    endcase
                end
            end
            S_COPY: begin
                // One byte out per cycle, next read issued alongside
                n_res_valid = 1'b1;
                res_byte    = i_ram_rdata;
                res_bv      = 1'b1;
                res_rl      = r_rl;
                res_last    = (r_cnt == 6'd1);
                o_ram_raddr = r_idx;
                n_idx       = next_idx(r_idx, len);
                n_cnt       = r_cnt - 6'd1;
                if (r_cnt == 6'd1) n_state = S_IDLE;
            end
            S_FILL: begin
                // One entry written per cycle
                o_ram_wr.we    = 1'b1;
                o_ram_wr.waddr = r_idx;
                o_ram_wr.wdata = r_fill;
                n_idx          = next_idx(r_idx, len);
                n_cnt          = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state     = S_IDLE;
                    n_res_valid = 1'b1;
                    res_rl      = r_rl;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Append write at the tail
        if (put) begin
            o_ram_wr.we    = 1'b1;
            o_ram_wr.waddr = r_tail;
            o_ram_wr.wdata = i_item.data_byte;
            n_tail         = next_idx(r_tail, len);
            n_held         = r_held + 7'd1;
        end

        // Result carries state after the transaction
        if (n_res_valid) begin
            n_res.status           = res_status;
            n_res.read_byte        = res_byte;
            n_res.byte_valid       = res_bv;
            n_res.range_length     = res_rl;
            n_res.stored_count     = n_held;
            n_res.start_position   = n_head;
            n_res.overflow_events  = n_ovf;
            n_res.lost_bytes_total = n_lost;
            n_res.last             = res_last;
        end

        // Ring length change pulls positions and count inside the new length
        if (i_cfg.wr) begin
            if (head7 >= new_len) n_head = '0;
            if ({1'b0, r_tail} >= new_len) n_tail = '0;
            if (r_held > new_len) n_held = new_len;
        end
    end

    assign o_result    = r_res;
    assign o_res_valid = r_res_valid;

endmodule

// File: rtl/byte_ring_buffer_with_admission_top.sv
// Top level: byte ring buffer with whole-message admission and APB configuration.
//
// Usage:
//   Commands: drive i_item and raise start; a transaction is taken at a clock edge
//   with start high and busy low. Results appear on o_result for one cycle with
//   o_res_valid high; the receiver must take them, there is no back-pressure.
//   Append, set start, measure, bad opcodes, rejected ranges, empty copy or fill:
//   one result in the next cycle; busy stays low, so a command per cycle.
//   Copy of N bytes: each byte passes the store read register, then the result
//   register; one byte per cycle leaves while busy, through the single store read port.
//   Fill of N bytes: busy while the N entries are written, one store write per
//   cycle; the single result is registered after the last write.
//   Config: APB, ring_length at byte address 0; write only while the block is
//   idle. pready is always high.
//   Reset (i_rst_n low, synchronous): positions, counters and message state go
//   to zero, ring_length to 64, and every store entry reads as zero until written.
module byte_ring_buffer_with_admission_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  brba_pkg::t_item                 i_item,
    output logic                            busy,
    output brba_pkg::t_result               o_result,
    output logic                            o_res_valid,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brba_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import brba_pkg::*;

    logic [6:0]       ring_length;
    t_cfg_wr          cfg;
    t_ram_wr          ram_wr;
    logic [IDX_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    brba_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_ring_length (ring_length),
        .o_cfg         (cfg)
    );

    brba_ram #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (ram_wr),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    brba_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_item        (i_item),
        .o_busy        (busy),
        .i_ring_length (ring_length),
        .i_cfg         (cfg),
        .o_ram_wr      (ram_wr),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_result      (o_result),
        .o_res_valid   (o_res_valid)
    );

endmodule
